### hdl/cccol_pkg.sv
package cccol_pkg;

  localparam int IN_W    = 32;
  localparam int RAD_W   = 31;
  localparam int D_W     = IN_W + 1;
  localparam int RS_W    = RAD_W + 1;
  localparam int P_W     = 2 * D_W;
  localparam int A_W     = P_W;
  localparam int H_W     = P_W + 1;
  localparam int C_W     = P_W + 1;
  localparam int M_W     = P_W;
  localparam int HALF_W  = M_W / 2;
  localparam int SQ_W    = 2 * M_W;
  localparam int E_W     = SQ_W + 2;
  localparam int SCALE_W = 32;
  localparam int S_W     = 84;
  localparam int X_W     = 2 * S_W;
  localparam int SREM_W  = S_W + 2;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = S_W + 2;
  localparam int NM_W    = NUM_W - 1;
  localparam int Q_W     = NM_W + 2;
  localparam int T_W     = 48;
  localparam int FRONT_ST = 7;
  localparam int LATENCY = FRONT_ST + S_W + 1 + NM_W + 2 + 1;

  localparam logic signed [T_W-1:0] TIME_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] TIME_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] QT_MAX = {{(Q_W-T_W+1){1'b0}}, {(T_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] QT_MIN = {{(Q_W-T_W+1){1'b1}}, {(T_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] first_pos_x;
    logic signed [IN_W-1:0] first_pos_y;
    logic signed [IN_W-1:0] first_vel_x;
    logic signed [IN_W-1:0] first_vel_y;
    logic [RAD_W-1:0]       first_radius;
    logic signed [IN_W-1:0] second_pos_x;
    logic signed [IN_W-1:0] second_pos_y;
    logic signed [IN_W-1:0] second_vel_x;
    logic signed [IN_W-1:0] second_vel_y;
    logic [RAD_W-1:0]       second_radius;
  } cccol_in_t;

  typedef struct packed {
    logic                  hit;
    logic                  no_motion;
    logic                  clipped;
    logic signed [T_W-1:0] time_first;
    logic signed [T_W-1:0] time_second;
  } cccol_out_t;

  typedef struct packed {
    logic                    no_motion;
    logic                    miss;
    logic [A_W-1:0]          a;
    logic signed [NUM_W-1:0] nh;
  } sq_side_t;

  typedef struct packed {
    logic no_motion;
    logic miss;
  } div_side_t;

endpackage

### hdl/cccol_front.sv
module cccol_front import cccol_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  cccol_in_t      in_item,
  output logic           out_valid,
  output logic [X_W-1:0] out_x,
  output sq_side_t       out_side
);

  logic [FRONT_ST-1:0] vld;

  logic signed [D_W-1:0] dpx, dpy, dvx, dvy;
  logic [RS_W-1:0]       rs;

  logic signed [P_W-1:0] px2, py2, vx2, vy2, pxv, pyv;
  logic [2*RS_W-1:0]     rr;

  logic [A_W-1:0]        a3;
  logic signed [H_W-1:0] h3;
  logic signed [C_W-1:0] c3;

  logic [A_W-1:0]        a4;
  logic signed [H_W-1:0] h4;
  logic [M_W-1:0]        habs, cabs;
  logic                  cneg4, nm4;

  logic [A_W-1:0]        a5;
  logic signed [H_W-1:0] h5;
  logic                  cneg5, nm5;
  logic [2*HALF_W-1:0]   p_hll, p_hlh, p_hhh, p_all, p_alh, p_ahl, p_ahh;

  logic [A_W-1:0]        a6;
  logic signed [H_W-1:0] h6;
  logic                  cneg6, nm6;
  logic [SQ_W-1:0]       hh, ac;

  logic [A_W-1:0]          a7;
  logic signed [NUM_W-1:0] nh7;
  logic                    nm7;
  logic signed [E_W-1:0]   e7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // relative motion
    dpx <= D_W'(in_item.second_pos_x) - D_W'(in_item.first_pos_x);
    dpy <= D_W'(in_item.second_pos_y) - D_W'(in_item.first_pos_y);
    dvx <= D_W'(in_item.second_vel_x) - D_W'(in_item.first_vel_x);
    dvy <= D_W'(in_item.second_vel_y) - D_W'(in_item.first_vel_y);
    rs  <= RS_W'(in_item.first_radius) + RS_W'(in_item.second_radius);

    px2 <= dpx * dpx;
    py2 <= dpy * dpy;
    vx2 <= dvx * dvx;
    vy2 <= dvy * dvy;
    pxv <= dpx * dvx;
    pyv <= dpy * dvy;
    rr  <= rs * rs;

    a3 <= $unsigned(vx2) + $unsigned(vy2);
    h3 <= H_W'(pxv) + H_W'(pyv);
    c3 <= C_W'(px2) + C_W'(py2) - C_W'(rr);

    a4    <= a3;
    h4    <= h3;
    nm4   <= (a3 == '0);
    habs  <= h3[H_W-1] ? M_W'(-h3) : M_W'(h3);
    cabs  <= c3[C_W-1] ? M_W'(-c3) : M_W'(c3);
    cneg4 <= c3[C_W-1];

    // split products for h*h and a*c
    a5    <= a4;
    h5    <= h4;
    nm5   <= nm4;
    cneg5 <= cneg4;
    p_hll <= habs[HALF_W-1:0] * habs[HALF_W-1:0];
    p_hlh <= habs[HALF_W-1:0] * habs[M_W-1:HALF_W];
    p_hhh <= habs[M_W-1:HALF_W] * habs[M_W-1:HALF_W];
    p_all <= a4[HALF_W-1:0] * cabs[HALF_W-1:0];
    p_alh <= a4[HALF_W-1:0] * cabs[M_W-1:HALF_W];
    p_ahl <= a4[A_W-1:HALF_W] * cabs[HALF_W-1:0];
    p_ahh <= a4[A_W-1:HALF_W] * cabs[M_W-1:HALF_W];

    a6    <= a5;
    h6    <= h5;
    nm6   <= nm5;
    cneg6 <= cneg5;
    hh <= (SQ_W'(p_hhh) << (2 * HALF_W)) + (SQ_W'(p_hlh) << (HALF_W + 1))
        + SQ_W'(p_hll);
    ac <= (SQ_W'(p_ahh) << (2 * HALF_W))
        + ((SQ_W'(p_alh) + SQ_W'(p_ahl)) << HALF_W) + SQ_W'(p_all);

    a7  <= a6;
    nm7 <= nm6;
    nh7 <= -(NUM_W'(h6) <<< FRAC_W);
    e7  <= cneg6 ? E_W'(hh) + E_W'(ac) : E_W'(hh) - E_W'(ac);
  end

  always_comb begin
    out_valid          = vld[FRONT_ST-1];
    out_x              = {{(X_W-E_W-SCALE_W){1'b0}}, e7, {SCALE_W{1'b0}}};
    out_side.no_motion = nm7;
    out_side.miss      = e7[E_W-1];
    out_side.a         = a7;
    out_side.nh        = nh7;
  end

endmodule

### hdl/cccol_sqrt.sv
module cccol_sqrt import cccol_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [X_W-1:0] in_x,
  input  sq_side_t       in_side,
  output logic           out_valid,
  output logic [S_W-1:0] out_root,
  output sq_side_t       out_side
);

  logic [S_W-1:0]    vld;
  logic [X_W-1:0]    xs   [S_W];
  logic [SREM_W-1:0] rem  [S_W];
  logic [S_W-1:0]    root [S_W];
  sq_side_t          side [S_W];

  logic [X_W-1:0]    x_prev [S_W];
  logic [SREM_W-1:0] r_prev [S_W];
  logic [S_W-1:0]    q_prev [S_W];
  sq_side_t          s_prev [S_W];
  logic [SREM_W+1:0] r2     [S_W];
  logic [SREM_W+1:0] trial  [S_W];
  logic [S_W-1:0]    take;

  always_comb begin
    x_prev[0] = in_x;
    r_prev[0] = '0;
    q_prev[0] = '0;
    s_prev[0] = in_side;
    for (int i = 1; i < S_W; i++) begin
      x_prev[i] = xs[i-1];
      r_prev[i] = rem[i-1];
      q_prev[i] = root[i-1];
      s_prev[i] = side[i-1];
    end
    // one root digit per stage
    for (int i = 0; i < S_W; i++) begin
      r2[i]    = {r_prev[i], x_prev[i][X_W-1 -: 2]};
      trial[i] = (SREM_W+2)'({q_prev[i], 2'b01});
      take[i]  = (r2[i] >= trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[S_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < S_W; i++) begin
      xs[i]   <= x_prev[i] << 2;
      rem[i]  <= take[i] ? SREM_W'(r2[i] - trial[i]) : SREM_W'(r2[i]);
      root[i] <= {q_prev[i][S_W-2:0], take[i]};
      side[i] <= s_prev[i];
    end
  end

  assign out_valid = vld[S_W-1];
  assign out_root  = root[S_W-1];
  assign out_side  = side[S_W-1];

endmodule

### hdl/cccol_div.sv
module cccol_div import cccol_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [NUM_W-1:0] num_first,
  input  logic signed [NUM_W-1:0] num_second,
  input  logic [A_W-1:0]        in_a,
  input  div_side_t             in_side,
  output logic                  out_valid,
  output logic signed [Q_W-1:0] q_first,
  output logic signed [Q_W-1:0] q_second,
  output div_side_t             out_side
);

  logic [NM_W+1:0] vld;

  // sign split
  logic [1:0][NM_W-1:0] mag0;
  logic [1:0]           neg0;
  logic [A_W-1:0]       a0;
  div_side_t            side0;

  // long division stages
  logic [1:0][NM_W-1:0] m    [NM_W];
  logic [1:0][NM_W-1:0] q    [NM_W];
  logic [1:0][A_W-1:0]  rem  [NM_W];
  logic [1:0]           ng   [NM_W];
  logic [A_W-1:0]       a_s  [NM_W];
  div_side_t            sd   [NM_W];

  logic [1:0][NM_W-1:0] m_prev [NM_W];
  logic [1:0][NM_W-1:0] q_prev [NM_W];
  logic [1:0][A_W-1:0]  r_prev [NM_W];
  logic [1:0]           n_prev [NM_W];
  logic [A_W-1:0]       a_prev [NM_W];
  div_side_t            s_prev [NM_W];
  logic [1:0][A_W:0]    r2     [NM_W];
  logic [1:0]           ge     [NM_W];

  always_comb begin
    m_prev[0] = mag0;
    q_prev[0] = '0;
    r_prev[0] = '0;
    n_prev[0] = neg0;
    a_prev[0] = a0;
    s_prev[0] = side0;
    for (int i = 1; i < NM_W; i++) begin
      m_prev[i] = m[i-1];
      q_prev[i] = q[i-1];
      r_prev[i] = rem[i-1];
      n_prev[i] = ng[i-1];
      a_prev[i] = a_s[i-1];
      s_prev[i] = sd[i-1];
    end
    for (int i = 0; i < NM_W; i++) begin
      for (int l = 0; l < 2; l++) begin
        r2[i][l] = {r_prev[i][l], m_prev[i][l][NM_W-1]};
        ge[i][l] = (r2[i][l] >= {1'b0, a_prev[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NM_W:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    mag0[0] <= num_first[NUM_W-1] ? NM_W'(-num_first) : NM_W'(num_first);
    mag0[1] <= num_second[NUM_W-1] ? NM_W'(-num_second) : NM_W'(num_second);
    neg0    <= {num_second[NUM_W-1], num_first[NUM_W-1]};
    a0      <= in_a;
    side0   <= in_side;

    for (int i = 0; i < NM_W; i++) begin
      for (int l = 0; l < 2; l++) begin
        m[i][l]   <= m_prev[i][l] << 1;
        q[i][l]   <= {q_prev[i][l][NM_W-2:0], ge[i][l]};
        rem[i][l] <= ge[i][l] ? A_W'(r2[i][l] - {1'b0, a_prev[i]}) : A_W'(r2[i][l]);
      end
      ng[i]  <= n_prev[i];
      a_s[i] <= a_prev[i];
      sd[i]  <= s_prev[i];
    end

    // floor toward minus infinity for negative dividends
    q_first <= ng[NM_W-1][0]
             ? -(Q_W'(q[NM_W-1][0]) + Q_W'(rem[NM_W-1][0] != '0))
             : Q_W'(q[NM_W-1][0]);
    q_second <= ng[NM_W-1][1]
              ? -(Q_W'(q[NM_W-1][1]) + Q_W'(rem[NM_W-1][1] != '0))
              : Q_W'(q[NM_W-1][1]);
    out_side <= sd[NM_W-1];
  end

  assign out_valid = vld[NM_W+1];

endmodule

### hdl/circle_circle_collision_time_core.sv
// throughput: one transaction per cycle, busy is never raised
// front end 7 stages, square root 84 stages (one bit each), divider 87 stages
// (one quotient bit per stage per root), plus root combine and output register
// synchronous reset clears all valid bits, in-flight transactions are dropped
module circle_circle_collision_time_core import cccol_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cccol_in_t  query,
  output logic       done,
  output cccol_out_t result
);

  logic           fr_valid;
  logic [X_W-1:0] fr_x;
  sq_side_t       fr_side;

  logic           sq_valid;
  logic [S_W-1:0] sq_root;
  sq_side_t       sq_side;

  logic                    nm_valid;
  logic signed [NUM_W-1:0] num_first, num_second;
  logic [A_W-1:0]          nm_a;
  div_side_t               nm_side;

  logic                  dv_valid;
  logic signed [Q_W-1:0] q_first, q_second;
  div_side_t             dv_side;

  logic       hi_first, lo_first, hi_second, lo_second, hit_c;
  cccol_out_t result_next;

  assign busy = 1'b0;

  cccol_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_item   (query),
    .out_valid (fr_valid),
    .out_x     (fr_x),
    .out_side  (fr_side)
  );

  cccol_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_x      (fr_x),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else begin
      nm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    num_first         <= sq_side.nh - NUM_W'(sq_root);
    num_second        <= sq_side.nh + NUM_W'(sq_root);
    nm_a              <= sq_side.a;
    nm_side.no_motion <= sq_side.no_motion;
    nm_side.miss      <= sq_side.miss;
  end

  cccol_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (nm_valid),
    .num_first  (num_first),
    .num_second (num_second),
    .in_a       (nm_a),
    .in_side    (nm_side),
    .out_valid  (dv_valid),
    .q_first    (q_first),
    .q_second   (q_second),
    .out_side   (dv_side)
  );

  always_comb begin
    hi_first  = (q_first > QT_MAX);
    lo_first  = (q_first < QT_MIN);
    hi_second = (q_second > QT_MAX);
    lo_second = (q_second < QT_MIN);
    hit_c     = !dv_side.no_motion && !dv_side.miss;

    result_next.hit       = hit_c;
    result_next.no_motion = dv_side.no_motion;
    result_next.clipped   = hit_c && (hi_first || lo_first || hi_second || lo_second);
    result_next.time_first  = '0;
    result_next.time_second = '0;
    if (hit_c) begin
      result_next.time_first = hi_first ? TIME_MAX
                             : lo_first ? TIME_MIN : q_first[T_W-1:0];
      result_next.time_second = hi_second ? TIME_MAX
                              : lo_second ? TIME_MIN : q_second[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && result.no_motion))
    else $error("hit and no_motion both set");

  a_miss_quiet: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |->
      result.time_first == '0 && result.time_second == '0 && !result.clipped)
    else $error("times or clip set on a miss");

  a_root_order: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> $signed(result.time_first) <= $signed(result.time_second))
    else $error("roots out of order");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("transaction result missing at expected latency");
`endif

endmodule

### tb/sv/testbench.sv
module testbench;
  import cccol_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;

  // predicted collision times, kept in arrival order
  class collision_scoreboard;
    cccol_out_t pending_times[$];
    int errors;

    function automatic logic signed [T_W-1:0] clamp_time(logic signed [255:0] q, ref logic clip);
      logic signed [255:0] hi;
      logic signed [255:0] lo;
      hi = 256'sh7FFF_FFFF_FFFF;
      lo = -(256'sh8000_0000_0000);
      if (q > hi) begin
        clip = 1'b1;
        return TIME_MAX;
      end
      if (q < lo) begin
        clip = 1'b1;
        return TIME_MIN;
      end
      return q[T_W-1:0];
    endfunction

    function automatic logic signed [255:0] floor_div(logic signed [255:0] n,
                                                      logic signed [255:0] d);
      logic signed [255:0] q;
      q = n / d;
      if ((n % d != 0) && (n < 0)) q = q - 1;
      return q;
    endfunction

    function automatic logic [255:0] int_sqrt(logic [255:0] x);
      logic [255:0] r;
      logic [255:0] cand;
      r = '0;
      for (int i = 83; i >= 0; i--) begin
        cand = r | (256'd1 << i);
        if (cand * cand <= x) r = cand;
      end
      return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    function automatic void note_query(cccol_in_t q);
      logic signed [255:0] px, py, vx, vy, rs, a, h, c, e, s, nh;
      logic clip;
      cccol_out_t r;
      px = 256'(signed'(q.second_pos_x)) - 256'(signed'(q.first_pos_x));
      py = 256'(signed'(q.second_pos_y)) - 256'(signed'(q.first_pos_y));
      vx = 256'(signed'(q.second_vel_x)) - 256'(signed'(q.first_vel_x));
      vy = 256'(signed'(q.second_vel_y)) - 256'(signed'(q.first_vel_y));
      rs = 256'(q.first_radius) + 256'(q.second_radius);
      a = vx * vx + vy * vy;
      h = px * vx + py * vy;
      c = px * px + py * py - rs * rs;
      r = '0;
      clip = 1'b0;
      if (a == 0) begin
        r.no_motion = 1'b1;
      end else begin
        e = h * h - a * c;
        if (e >= 0) begin
          s = int_sqrt(e <<< 32);
          nh = -(h <<< 16);
          r.time_first = clamp_time(floor_div(nh - s, a), clip);
          r.time_second = clamp_time(floor_div(nh + s, a), clip);
          r.hit = 1'b1;
          r.clipped = clip;
        end
      end
      pending_times.push_back(r);
    endfunction

    task automatic check_result(cccol_out_t got);
      cccol_out_t want;
      if (pending_times.size() == 0) begin
        report_mismatch("result with none pending", 0, 0);
        return;
      end
      want = pending_times.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.no_motion !== want.no_motion)
        report_mismatch("no_motion", got.no_motion, want.no_motion);
      if (got.clipped !== want.clipped) report_mismatch("clipped", got.clipped, want.clipped);
      if (got.time_first !== want.time_first)
        report_mismatch("time_first", got.time_first, want.time_first);
      if (got.time_second !== want.time_second)
        report_mismatch("time_second", got.time_second, want.time_second);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  cccol_in_t query = '0;
  cccol_out_t result;

  collision_scoreboard board = new();
  int idle_cycles = 0;
  logic timed_out = 1'b0;
  logic no_gaps = 1'b0;

  circle_circle_collision_time_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .query(query),
    .done(done),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 50)) << 16;
      1: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: return 31'($urandom);
    endcase
  endfunction

  // one transaction: drive, then hold until accepted
  task automatic send_query(cccol_in_t q);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 31) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    query <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_query(q);
  endtask

  task automatic send_random();
    cccol_in_t q;
    q.first_pos_x = rand_coord();
    q.first_pos_y = rand_coord();
    q.first_vel_x = rand_coord();
    q.first_vel_y = rand_coord();
    q.first_radius = rand_radius();
    q.second_pos_x = rand_coord();
    q.second_pos_y = rand_coord();
    q.second_vel_x = $urandom_range(0, 9) == 0 ? q.first_vel_x : rand_coord();
    q.second_vel_y = $urandom_range(0, 9) == 0 ? q.first_vel_y : rand_coord();
    q.second_radius = rand_radius();
    send_query(q);
  endtask

  task automatic send_pair(logic signed [31:0] px, logic signed [31:0] vx,
                           logic [30:0] r1, logic [30:0] r2,
                           logic signed [31:0] p2, logic signed [31:0] v2);
    cccol_in_t q;
    q = '0;
    q.first_pos_x = px;
    q.first_vel_x = vx;
    q.first_radius = r1;
    q.second_pos_x = p2;
    q.second_vel_x = v2;
    q.second_radius = r2;
    send_query(q);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending_times.size() != 0 && !timed_out) @(posedge clk);
  endtask

  initial begin
    cccol_in_t q;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // head-on, no motion, miss, touching, extremes
    send_pair(32'sh0, 32'sh1_0000, 31'h1_0000, 31'h1_0000, 32'sh10_0000, 32'sh0);
    send_pair(32'sh0, 32'sh1_0000, 31'h1_0000, 31'h1_0000, 32'sh10_0000, 32'sh1_0000);
    send_pair(32'sh0, 32'sh0, 31'h0, 31'h0, 32'sh0, 32'sh0);
    send_pair(32'sh0, 32'sh0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh0, 32'sh1);
    send_pair(32'sh8000_0000, 32'sh0, 31'h0, 31'h0, 32'sh7FFF_FFFF, 32'sh1);
    send_pair(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h0,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_pair(32'sh0, 32'sh1_0000, 31'h0, 31'h0, 32'sh4_0000, 32'sh0);
    send_pair(32'sh0, 32'sh0, 31'h8000, 31'h8000, 32'sh5_0000, 32'sh7FFF_FFFF);
    send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000);
    q = '1;
    send_query(q);
    q = '0;
    q.first_pos_y = 32'sh10_0000;
    q.second_vel_y = 32'sh2_0000;
    q.first_radius = 31'h3_0000;
    send_query(q);
    // pass sideways, missing
    q = '0;
    q.first_pos_y = 32'sh100_0000;
    q.second_vel_x = 32'sh1_0000;
    q.second_pos_x = 32'shF000_0000;
    q.second_radius = 31'h1_0000;
    send_query(q);

    wait_drained();
    for (int i = 0; i < 150; i++) send_random();
    no_gaps = 1'b1;
    for (int i = 0; i < 100; i++) send_random();
    no_gaps = 1'b0;
    for (int i = 0; i < 200; i++) send_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && !timed_out) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("end of test: mismatches");
    $finish;
  end
endmodule

### filelist.f
hdl/cccol_pkg.sv
hdl/cccol_front.sv
hdl/cccol_sqrt.sv
hdl/cccol_div.sv
hdl/circle_circle_collision_time_core.sv
tb/sv/testbench.sv
